@@ rtl/core/cubic_bspline_evaluator_assert.svh @@
// Assertion macros for the cubic B-spline evaluator.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef CUBIC_BSPLINE_EVALUATOR_ASSERT_SVH
`define CUBIC_BSPLINE_EVALUATOR_ASSERT_SVH

// cond must hold at every clock edge outside reset
`define CBE_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// pre at one edge implies post at the next edge
`define CBE_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ rtl/core/cbe_pkg.sv @@
// Types and constants of the cubic B-spline evaluator.
// No dependencies.
package cbe_pkg;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_SEG   = 2'd1,
      STATUS_INDEX = 2'd2
   } status_type;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   localparam logic [16:0] T_ONE = 17'd65536;
   localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

   localparam int STAGES = 7;
   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_PTR_W = 4;
   localparam int FIFO_CNT_W = 5;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } point_type;

   typedef struct packed {
      logic       zero;
      status_type status;
   } tag_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [39:0] slope_x;
      logic signed [39:0] slope_y;
      logic signed [39:0] bend_x;
      logic signed [39:0] bend_y;
      status_type         status;
   } result_type;

endpackage

@@ rtl/core/cubic_bspline_evaluator.sv @@
// Top level of the uniform cubic B-spline evaluator: point tables, weight and blend pipeline.
// Depends on cbe_pkg and cubic_bspline_evaluator_assert.svh.
//
// channel | direction | words
// req_*   | in        | load a control point or evaluate at (segment, t)
// rsp_*   | out       | position, slope, bend, status
// csr_*   | in        | control_count
//
// One word per cycle while req_ready is high; a taken word passes stages s1 to s7, then the result queue.
// Points live in two banks (even/odd index), each read at two rows per cycle.
// A 16-word result queue sits at the output; req_ready drops only when 16 words
// are in flight. Synchronous reset; the point banks are not cleared.
module cubic_bspline_evaluator #(
   parameter int MAX_CONTROLS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [5:0]          req_point_index,
   input  logic signed [31:0]  req_ctrl_x,
   input  logic signed [31:0]  req_ctrl_y,
   input  logic [5:0]          req_segment,
   input  logic [16:0]         req_t_frac,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_pos_x,
   output logic signed [31:0]  rsp_pos_y,
   output logic signed [39:0]  rsp_slope_x,
   output logic signed [39:0]  rsp_slope_y,
   output logic signed [39:0]  rsp_bend_x,
   output logic signed [39:0]  rsp_bend_y,
   output cbe_pkg::status_type rsp_status,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [6:0]          csr_control_count
);
   import cbe_pkg::*;
   `include "cubic_bspline_evaluator_assert.svh"

   localparam int HALF_DEPTH = (MAX_CONTROLS + 1) / 2;
   localparam int ROW_W = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
   localparam logic [11:0] MAX12 = 12'(MAX_CONTROLS);

   function automatic logic signed [31:0] rnd5(input logic signed [37:0] x);
      logic signed [37:0] r;
      if (x < 0) r = (x + 38'sd15) >>> 5;
      else r = (x + 38'sd16) >>> 5;
      return r[31:0];
   endfunction

   function automatic logic signed [65:0] rnd28(input logic signed [65:0] s);
      logic signed [65:0] r;
      if (s < 0) r = (s + 66'sd134217727) >>> 28;
      else r = (s + 66'sd134217728) >>> 28;
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (v < -66'sd2147483648) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [39:0] sat40(input logic signed [65:0] v);
      logic signed [39:0] r;
      if (v > 66'sd549755813887) r = 40'sh7F_FFFF_FFFF;
      else if (v < -66'sd549755813888) r = 40'sh80_0000_0000;
      else r = v[39:0];
      return r;
   endfunction

   // handshake and control
   logic                  in_fire, out_fire, fifo_push;
   logic [6:0]            control_count_ff;
   logic [FIFO_CNT_W-1:0] inflight_ff, inflight_in;
   logic [STAGES-1:0]     stage_valid_ff;
   tag_type               tag_ff [STAGES];
   tag_type               tag_in;

   // memories
   point_type             even_ram_ff [HALF_DEPTH];
   point_type             odd_ram_ff [HALF_DEPTH];
   point_type             ev_a_ff, ev_b_ff, od_a_ff, od_b_ff;
   logic [11:0]           wr_idx12, k12, kp1, cnt_eff;
   logic [ROW_W-1:0]      wr_row, ev_row_a, ev_row_b, od_row_a, od_row_b;
   logic                  we_even, we_odd, idx_bad, seg_bad;

   // s1
   logic [16:0]           s1_u_ff;
   logic                  s1_odd_ff;
   // s2
   logic [32:0]           s2_u2_ff, s2_v2_ff;
   logic [16:0]           s2_u_ff, s2_v_ff;
   point_type             s2_pts_ff [4];
   // s3
   logic [48:0]           s3_u3_ff, s3_v3_ff;
   logic [32:0]           s3_u2_ff;
   logic [16:0]           s3_u_ff;
   logic signed [31:0]    s3_ndw_ff [4];
   logic signed [31:0]    s3_nsw_ff [4];
   point_type             s3_pts_ff [4];
   logic signed [31:0]    ndw_in [4];
   logic signed [31:0]    nsw_in [4];
   // s4
   logic [31:0]           s4_y_ff [4];
   logic signed [31:0]    s4_ndw_ff [4];
   logic signed [31:0]    s4_nsw_ff [4];
   point_type             s4_pts_ff [4];
   logic [31:0]           y_in [4];
   // s5
   logic [63:0]           s5_q_ff [4];
   logic signed [31:0]    s5_ndw_ff [4];
   logic signed [31:0]    s5_nsw_ff [4];
   point_type             s5_pts_ff [4];
   // s6
   logic signed [63:0]    pb_x_ff [4], pb_y_ff [4];
   logic signed [63:0]    pd_x_ff [4], pd_y_ff [4];
   logic signed [63:0]    ps_x_ff [4], ps_y_ff [4];
   // s7
   logic signed [65:0]    sum_ff [6];
   // result queue
   result_type            fifo_ff [FIFO_DEPTH];
   result_type            res_in;
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] fifo_count_ff, fifo_count_in;

   assign req_ready = (inflight_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign csr_ready = 1'b1;
   assign in_fire   = req_valid && req_ready;
   assign rsp_valid = (fifo_count_ff != '0);
   assign out_fire  = rsp_valid && rsp_ready;
   assign fifo_push = stage_valid_ff[STAGES-1];

   // address and range decode
   always_comb begin
      wr_idx12 = {6'b0, req_point_index};
      k12      = {6'b0, req_segment};
      kp1      = k12 + 12'd1;
      cnt_eff  = ({5'b0, control_count_ff} > MAX12) ? MAX12 : {5'b0, control_count_ff};
      idx_bad  = (wr_idx12 >= MAX12);
      seg_bad  = ((k12 + 12'd4) > cnt_eff);
      wr_row   = wr_idx12[ROW_W:1];
      ev_row_a = kp1[ROW_W:1];
      ev_row_b = ev_row_a + ROW_W'(1);
      od_row_a = k12[ROW_W:1];
      od_row_b = od_row_a + ROW_W'(1);
      we_even  = in_fire && (req_type == REQ_LOAD) && !idx_bad && !req_point_index[0];
      we_odd   = in_fire && (req_type == REQ_LOAD) && !idx_bad && req_point_index[0];
      tag_in.zero = (req_type == REQ_LOAD) || seg_bad;
      if (req_type == REQ_LOAD) tag_in.status = idx_bad ? STATUS_INDEX : STATUS_OK;
      else tag_in.status = seg_bad ? STATUS_SEG : STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (we_even) even_ram_ff[wr_row] <= '{x: req_ctrl_x, y: req_ctrl_y};
      if (we_odd) odd_ram_ff[wr_row] <= '{x: req_ctrl_x, y: req_ctrl_y};
      ev_a_ff <= even_ram_ff[ev_row_a];
      ev_b_ff <= even_ram_ff[ev_row_b];
      od_a_ff <= odd_ram_ff[od_row_a];
      od_b_ff <= odd_ram_ff[od_row_b];
   end

   // control registers
   always_comb begin
      inflight_in = inflight_ff;
      unique case ({in_fire, out_fire})
         2'b10:   inflight_in = inflight_ff + FIFO_CNT_W'(1);
         2'b01:   inflight_in = inflight_ff - FIFO_CNT_W'(1);
         default: inflight_in = inflight_ff;
      endcase
      fifo_count_in = fifo_count_ff;
      unique case ({fifo_push, out_fire})
         2'b10:   fifo_count_in = fifo_count_ff + FIFO_CNT_W'(1);
         2'b01:   fifo_count_in = fifo_count_ff - FIFO_CNT_W'(1);
         default: fifo_count_in = fifo_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_count_ff <= 7'd4;
         inflight_ff      <= '0;
         stage_valid_ff   <= '0;
         fifo_count_ff    <= '0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
      end else begin
         if (csr_valid && csr_ready) control_count_ff <= csr_control_count;
         inflight_ff    <= inflight_in;
         stage_valid_ff <= {stage_valid_ff[STAGES-2:0], in_fire};
         fifo_count_ff  <= fifo_count_in;
         if (fifo_push) wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         if (out_fire) rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= tag_in;
      for (int i = 1; i < STAGES; i++) tag_ff[i] <= tag_ff[i-1];
   end

   // s1: saturated t, bank order
   always_ff @(posedge clock) begin
      s1_u_ff   <= (req_t_frac > T_ONE) ? T_ONE : req_t_frac;
      s1_odd_ff <= req_segment[0];
   end

   // s2: squares, points in segment order
   always_ff @(posedge clock) begin
      s2_u_ff  <= s1_u_ff;
      s2_v_ff  <= T_ONE - s1_u_ff;
      s2_u2_ff <= 33'(34'(s1_u_ff) * 34'(s1_u_ff));
      s2_v2_ff <= 33'(34'(T_ONE - s1_u_ff) * 34'(T_ONE - s1_u_ff));
      if (s1_odd_ff) begin
         s2_pts_ff[0] <= od_a_ff;
         s2_pts_ff[1] <= ev_a_ff;
         s2_pts_ff[2] <= od_b_ff;
         s2_pts_ff[3] <= ev_b_ff;
      end else begin
         s2_pts_ff[0] <= ev_a_ff;
         s2_pts_ff[1] <= od_a_ff;
         s2_pts_ff[2] <= ev_b_ff;
         s2_pts_ff[3] <= od_b_ff;
      end
   end

   // s3: cubes, slope and bend weights
   always_comb begin
      logic signed [37:0] u2e, v2e, ush17, ush18, one32;
      logic signed [31:0] ue;
      u2e   = $signed({5'b0, s2_u2_ff});
      v2e   = $signed({5'b0, s2_v2_ff});
      ush17 = $signed({4'b0, s2_u_ff, 17'b0});
      ush18 = $signed({3'b0, s2_u_ff, 18'b0});
      one32 = 38'sd4294967296;
      ndw_in[0] = rnd5(-v2e);
      ndw_in[1] = rnd5(38'sd3 * u2e - ush18);
      ndw_in[2] = rnd5(-38'sd3 * u2e + ush17 + one32);
      ndw_in[3] = rnd5(u2e);
      ue = $signed({15'b0, s2_u_ff});
      nsw_in[0] = (32'sd65536 - ue) * 32'sd4096;
      nsw_in[1] = (32'sd3 * ue - 32'sd131072) * 32'sd4096;
      nsw_in[2] = (32'sd65536 - 32'sd3 * ue) * 32'sd4096;
      nsw_in[3] = ue * 32'sd4096;
   end

   always_ff @(posedge clock) begin
      s3_u3_ff  <= 49'(51'(s2_u2_ff) * 51'(s2_u_ff));
      s3_v3_ff  <= 49'(51'(s2_v2_ff) * 51'(s2_v_ff));
      s3_u2_ff  <= s2_u2_ff;
      s3_u_ff   <= s2_u_ff;
      s3_ndw_ff <= ndw_in;
      s3_nsw_ff <= nsw_in;
      s3_pts_ff <= s2_pts_ff;
   end

   // s4: position numerators, rounded and pre-shifted
   always_comb begin
      logic signed [52:0] u3s, v3s, u2s, u1s, nb [4];
      logic [52:0]        rs [4];
      u3s = $signed({4'b0, s3_u3_ff});
      v3s = $signed({4'b0, s3_v3_ff});
      u2s = $signed({4'b0, s3_u2_ff, 16'b0});
      u1s = $signed({4'b0, s3_u_ff, 32'b0});
      nb[0] = v3s;
      nb[1] = 53'sd3 * u3s - 53'sd6 * u2s + (53'sd4 <<< 48);
      nb[2] = -53'sd3 * u3s + 53'sd3 * u2s + 53'sd3 * u1s + (53'sd1 <<< 48);
      nb[3] = u3s;
      for (int i = 0; i < 4; i++) begin
         rs[i]   = 53'(nb[i] + 53'sd3145728);
         y_in[i] = rs[i][52:21];
      end
   end

   always_ff @(posedge clock) begin
      s4_y_ff   <= y_in;
      s4_ndw_ff <= s3_ndw_ff;
      s4_nsw_ff <= s3_nsw_ff;
      s4_pts_ff <= s3_pts_ff;
   end

   // s5: divide by three
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) s5_q_ff[i] <= 64'(s4_y_ff[i]) * 64'(RECIP3);
      s5_ndw_ff <= s4_ndw_ff;
      s5_nsw_ff <= s4_nsw_ff;
      s5_pts_ff <= s4_pts_ff;
   end

   // s6: weight times point
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         pb_x_ff[i] <= $signed({1'b0, s5_q_ff[i][63:33]}) * 64'(s5_pts_ff[i].x);
         pb_y_ff[i] <= $signed({1'b0, s5_q_ff[i][63:33]}) * 64'(s5_pts_ff[i].y);
         pd_x_ff[i] <= 64'(s5_ndw_ff[i]) * 64'(s5_pts_ff[i].x);
         pd_y_ff[i] <= 64'(s5_ndw_ff[i]) * 64'(s5_pts_ff[i].y);
         ps_x_ff[i] <= 64'(s5_nsw_ff[i]) * 64'(s5_pts_ff[i].x);
         ps_y_ff[i] <= 64'(s5_nsw_ff[i]) * 64'(s5_pts_ff[i].y);
      end
   end

   // s7: sums
   always_ff @(posedge clock) begin
      sum_ff[0] <= 66'(pb_x_ff[0]) + 66'(pb_x_ff[1]) + 66'(pb_x_ff[2]) + 66'(pb_x_ff[3]);
      sum_ff[1] <= 66'(pb_y_ff[0]) + 66'(pb_y_ff[1]) + 66'(pb_y_ff[2]) + 66'(pb_y_ff[3]);
      sum_ff[2] <= 66'(pd_x_ff[0]) + 66'(pd_x_ff[1]) + 66'(pd_x_ff[2]) + 66'(pd_x_ff[3]);
      sum_ff[3] <= 66'(pd_y_ff[0]) + 66'(pd_y_ff[1]) + 66'(pd_y_ff[2]) + 66'(pd_y_ff[3]);
      sum_ff[4] <= 66'(ps_x_ff[0]) + 66'(ps_x_ff[1]) + 66'(ps_x_ff[2]) + 66'(ps_x_ff[3]);
      sum_ff[5] <= 66'(ps_y_ff[0]) + 66'(ps_y_ff[1]) + 66'(ps_y_ff[2]) + 66'(ps_y_ff[3]);
   end

   // round and saturate, or zero for loads and bad segments; queue
   always_comb begin
      res_in.status = tag_ff[STAGES-1].status;
      if (tag_ff[STAGES-1].zero) begin
         res_in.pos_x   = '0;
         res_in.pos_y   = '0;
         res_in.slope_x = '0;
         res_in.slope_y = '0;
         res_in.bend_x  = '0;
         res_in.bend_y  = '0;
      end else begin
         res_in.pos_x   = sat32(rnd28(sum_ff[0]));
         res_in.pos_y   = sat32(rnd28(sum_ff[1]));
         res_in.slope_x = sat40(rnd28(sum_ff[2]));
         res_in.slope_y = sat40(rnd28(sum_ff[3]));
         res_in.bend_x  = sat40(rnd28(sum_ff[4]));
         res_in.bend_y  = sat40(rnd28(sum_ff[5]));
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_push) fifo_ff[wr_ptr_ff] <= res_in;
   end

   assign rsp_pos_x   = fifo_ff[rd_ptr_ff].pos_x;
   assign rsp_pos_y   = fifo_ff[rd_ptr_ff].pos_y;
   assign rsp_slope_x = fifo_ff[rd_ptr_ff].slope_x;
   assign rsp_slope_y = fifo_ff[rd_ptr_ff].slope_y;
   assign rsp_bend_x  = fifo_ff[rd_ptr_ff].bend_x;
   assign rsp_bend_y  = fifo_ff[rd_ptr_ff].bend_y;
   assign rsp_status  = fifo_ff[rd_ptr_ff].status;

   `CBE_ASSERT(a_no_overflow, !(fifo_push && !out_fire && fifo_count_ff == FIFO_CNT_W'(FIFO_DEPTH)), "result queue overflow")
   `CBE_ASSERT(a_inflight, 32'(inflight_ff) == 32'(fifo_count_ff) + $countones(stage_valid_ff), "in-flight count mismatch")
   `CBE_ASSERT_NEXT(a_enter, in_fire, stage_valid_ff[0], "accepted word missing from pipeline")
   `CBE_ASSERT_NEXT(a_csr, csr_valid && csr_ready, control_count_ff == $past(csr_control_count), "control_count not written")

endmodule

@@ tb/cubic_bspline_evaluator_checker.sv @@
// Checker for the cubic B-spline evaluator: mirrors the point table and register,
// predicts each result word from accepted request words and compares. Depends on cbe_pkg.
module cubic_bspline_evaluator_checker #(
   parameter int MAX_CONTROLS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_type,
   input  logic [5:0]          req_point_index,
   input  logic signed [31:0]  req_ctrl_x,
   input  logic signed [31:0]  req_ctrl_y,
   input  logic [5:0]          req_segment,
   input  logic [16:0]         req_t_frac,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic signed [31:0]  rsp_pos_x,
   input  logic signed [31:0]  rsp_pos_y,
   input  logic signed [39:0]  rsp_slope_x,
   input  logic signed [39:0]  rsp_slope_y,
   input  logic signed [39:0]  rsp_bend_x,
   input  logic signed [39:0]  rsp_bend_y,
   input  cbe_pkg::status_type rsp_status,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [6:0]          csr_control_count,
   output int                  fail_count,
   output int                  pending
);
   import cbe_pkg::*;

   localparam longint WEIGHT_DIV = 64'sd6 <<< 20;
   localparam longint BLEND_DIV = 64'sd1 <<< 28;

   point_type  points [MAX_CONTROLS];
   logic [6:0] count_reg;
   result_type expected_words [$];

   function automatic longint round_div(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint clamp(longint v, int bits);
      longint hi, lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic void mix(longint num[4], int k, output longint rx, output longint ry);
      longint sx, sy, w;
      sx = 0;
      sy = 0;
      for (int i = 0; i < 4; i++) begin
         w = round_div(num[i], WEIGHT_DIV);
         sx += w * longint'(points[k + i].x);
         sy += w * longint'(points[k + i].y);
      end
      rx = round_div(sx, BLEND_DIV);
      ry = round_div(sy, BLEND_DIV);
   endfunction

   function automatic result_type evaluate_word(logic kind, logic [5:0] idx,
         logic signed [31:0] cx, logic signed [31:0] cy, logic [5:0] seg, logic [16:0] tf);
      result_type r;
      longint lim, u, t1, t2, t3, one, px, py, dx, dy, bx, by;
      longint nb[4], nd[4], ns[4];
      r = '0;
      r.status = STATUS_OK;
      if (kind == REQ_LOAD) begin
         if (idx >= MAX_CONTROLS) r.status = STATUS_INDEX;
         else points[idx] = '{x: cx, y: cy};
         return r;
      end
      lim = (count_reg > MAX_CONTROLS) ? MAX_CONTROLS : count_reg;
      if (longint'(seg) + 4 > lim) begin
         r.status = STATUS_SEG;
         return r;
      end
      u = (tf > T_ONE) ? longint'(T_ONE) : longint'(tf);
      t1 = u <<< 32;
      t2 = (u * u) <<< 16;
      t3 = u * u * u;
      one = 64'sd1 <<< 48;
      nb = '{-t3 + 3*t2 - 3*t1 + one, 3*t3 - 6*t2 + 4*one,
             -3*t3 + 3*t2 + 3*t1 + one, t3};
      nd = '{-3*t2 + 6*t1 - 3*one, 9*t2 - 12*t1, -9*t2 + 6*t1 + 3*one, 3*t2};
      ns = '{-6*t1 + 6*one, 18*t1 - 12*one, -18*t1 + 6*one, 6*t1};
      mix(nb, seg, px, py);
      mix(nd, seg, dx, dy);
      mix(ns, seg, bx, by);
      r.pos_x = 32'(clamp(px, 32));
      r.pos_y = 32'(clamp(py, 32));
      r.slope_x = 40'(clamp(dx, 40));
      r.slope_y = 40'(clamp(dy, 40));
      r.bend_x = 40'(clamp(bx, 40));
      r.bend_y = 40'(clamp(by, 40));
      return r;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type e;
      result_type p;
      if (reset) begin
         count_reg <= 7'd4;
         expected_words.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) count_reg <= csr_control_count;
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word");
               fail_count++;
            end else begin
               e = expected_words.pop_front();
               check_field("pos_x", e.pos_x, rsp_pos_x);
               check_field("pos_y", e.pos_y, rsp_pos_y);
               check_field("slope_x", e.slope_x, rsp_slope_x);
               check_field("slope_y", e.slope_y, rsp_slope_y);
               check_field("bend_x", e.bend_x, rsp_bend_x);
               check_field("bend_y", e.bend_y, rsp_bend_y);
               check_field("status", e.status, rsp_status);
            end
         end
         if (req_valid && req_ready) begin
            p = evaluate_word(req_type, req_point_index, req_ctrl_x, req_ctrl_y,
               req_segment, req_t_frac);
            expected_words = {expected_words, p};
         end
         pending <= expected_words.size();
      end
   end

endmodule

@@ tb/cubic_bspline_evaluator_tb.sv @@
// Testbench top for the cubic B-spline evaluator: clock, reset, stimulus and verdict.
// Depends on cbe_pkg, cubic_bspline_evaluator and cubic_bspline_evaluator_checker.
module cubic_bspline_evaluator_tb;
   import cbe_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_type = REQ_LOAD;
   logic [5:0]          req_point_index = '0;
   logic signed [31:0]  req_ctrl_x = '0;
   logic signed [31:0]  req_ctrl_y = '0;
   logic [5:0]          req_segment = '0;
   logic [16:0]         req_t_frac = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic signed [31:0]  rsp_pos_x, rsp_pos_y;
   logic signed [39:0]  rsp_slope_x, rsp_slope_y, rsp_bend_x, rsp_bend_y;
   status_type          rsp_status;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [6:0]          csr_control_count = 7'd4;
   int                  fail_count;
   int                  pending;
   int                  burst_left = 0;
   int                  stall_mode = 0;
   logic [63:0]         written = '0;

   always #5 clock = ~clock;

   cubic_bspline_evaluator DUT (.*);
   cubic_bspline_evaluator_checker checker_inst (.*);

   always @(posedge clock) begin
      if ((($time / 2000) % 3) == 0) rsp_ready <= 1'b1;
      else if (stall_mode == 0) rsp_ready <= ($urandom_range(0, 3) != 0);
      else rsp_ready <= ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 1);
   end

   // valid stays high across a burst; it drops only for a gap, a skip or a drain
   task automatic send_word(logic kind, logic [5:0] idx, logic [31:0] cx, logic [31:0] cy,
         logic [5:0] seg, logic [16:0] tf);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_type <= kind;
      req_point_index <= idx;
      req_ctrl_x <= cx;
      req_ctrl_y <= cy;
      req_segment <= seg;
      req_t_frac <= tf;
      if (kind == REQ_LOAD) written[idx] = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_count(logic [6:0] n);
      drain();
      csr_valid <= 1'b1;
      csr_control_count <= n;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_coord();
      unique case ($urandom_range(0, 3))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [16:0] rand_t();
      unique case ($urandom_range(0, 5))
         0: return 17'd0;
         1: return T_ONE;
         2: return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   // evaluate in-range segments only when their four points are written; out-of-range segments are sent too
   task automatic eval_random(int cnt);
      int seg;
      seg = $urandom_range(0, 63);
      if (seg + 4 <= 64 && !(&written[seg +: 4])) seg = 0;
      if (seg + 4 <= cnt && !(&written[seg +: 4])) seg = 64;
      if (seg < 64 && (seg + 4 > cnt || &written[seg +: 4]))
         send_word(REQ_EVAL, 6'($urandom), $urandom, $urandom, 6'(seg), rand_t());
      else begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   initial begin
      int cnt;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 4; i++)
         send_word(REQ_LOAD, 6'(i), (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000,
            (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, 6'd0, 17'd0);
      send_word(REQ_EVAL, 6'd0, 32'd0, 32'd0, 6'd0, 17'd0);
      send_word(REQ_EVAL, 6'd0, 32'd0, 32'd0, 6'd0, T_ONE);
      send_word(REQ_EVAL, 6'd0, 32'd0, 32'd0, 6'd0, 17'h1FFFF);
      send_word(REQ_EVAL, 6'd0, 32'd0, 32'd0, 6'd1, 17'd32768);
      send_word(REQ_EVAL, 6'h3F, 32'd0, 32'd0, 6'h3F, 17'd100);
      drain();
      for (int i = 0; i < 64; i++)
         send_word(REQ_LOAD, 6'(i), rand_coord(), rand_coord(), 6'd0, 17'd0);
      set_count(7'd64);
      send_word(REQ_EVAL, 6'd0, 32'd0, 32'd0, 6'd60, 17'd12345);
      send_word(REQ_EVAL, 6'd0, 32'd0, 32'd0, 6'd61, 17'd12345);
      set_count(7'd127);
      send_word(REQ_EVAL, 6'd0, 32'd0, 32'd0, 6'd60, T_ONE);
      set_count(7'd0);
      send_word(REQ_EVAL, 6'd0, 32'd0, 32'd0, 6'd0, T_ONE);
      for (int ph = 0; ph < 6; ph++) begin
         cnt = (ph == 5) ? 4 : $urandom_range(4, 127);
         set_count(7'(cnt));
         for (int n = 0; n < 230; n++) begin
            if ($urandom_range(0, 3) == 0)
               send_word(REQ_LOAD, 6'($urandom), rand_coord(), rand_coord(), 6'($urandom),
                  17'($urandom));
            else eval_random(cnt > 64 ? 64 : cnt);
         end
         if (ph == 2) drain();
      end
      drain();
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ cubic_bspline_evaluator.f @@
+incdir+rtl/core
rtl/core/cbe_pkg.sv
rtl/core/cubic_bspline_evaluator.sv
tb/cubic_bspline_evaluator_checker.sv
tb/cubic_bspline_evaluator_tb.sv
